// ===== rtl/efsa_pkg.sv =====
// shared types and constants for the earliest-free server assigner
package efsa_pkg;

	// fixed field widths
	localparam int TIME_W   = 32;
	localparam int SVC_W    = 16;
	localparam int OUT_ID_W = 7;
	localparam int CFG_W    = 7;

	// register reset value for the server count
	localparam logic [CFG_W-1:0] SIU_RESET = 7'd64;

	// item commands
	localparam logic CMD_CUSTOMER = 1'b0;
	localparam logic CMD_RESTART  = 1'b1;

	typedef logic [TIME_W-1:0] ftime_t;

	// controller states, one-hot
	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SIFT  = 4'b0100,
		S_DONE  = 4'b1000
	} efsa_state_t;

endpackage

// ===== rtl/efsa_heap_mem.sv =====
// heap entry memory: one write port, two registered read ports
module efsa_heap_mem #(
	parameter int DEPTH = 64,
	parameter int DW    = 39
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [DW-1:0]            rdata_a,
	output logic [DW-1:0]            rdata_b
);

	logic [DW-1:0] mem_q [DEPTH];

	// write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== rtl/efsa_ctrl.sv =====
// heap controller: clearing sweep, sift-down sequencer and output register
module efsa_ctrl #(
	parameter int MAX_SERVERS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  cmd,
	input  logic [efsa_pkg::SVC_W-1:0]            service_time,
	input  logic [$clog2(MAX_SERVERS+1)-1:0]      count_new,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [efsa_pkg::OUT_ID_W-1:0]         assigned_server,
	output logic [efsa_pkg::OUT_ID_W-1:0]         next_server,
	output logic [efsa_pkg::TIME_W-1:0]           next_free_time
);

	import efsa_pkg::*;

	localparam int AW = $clog2(MAX_SERVERS);
	localparam int CW = $clog2(MAX_SERVERS + 1);
	localparam int IDW = CW;
	localparam int DW = TIME_W + IDW;
	localparam int XW = AW + 2;
	localparam int RST_COUNT = (MAX_SERVERS < 64) ? MAX_SERVERS : 64;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SERVERS - 1);

	efsa_state_t state_q;
	logic [AW-1:0] clr_addr_q;
	logic restart_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	ftime_t mov_time_q;
	logic [IDW-1:0] mov_id_q;
	ftime_t top_time_q;
	logic [IDW-1:0] top_id_q;
	logic [IDW-1:0] assigned_q;
	logic out_valid_q;
	logic [OUT_ID_W-1:0] out_assigned_q;
	logic [OUT_ID_W-1:0] out_next_q;
	ftime_t out_time_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic [AW-1:0] rd_pos;
	logic [XW-1:0] rd_left;
	logic [XW-1:0] rd_right;
	logic [DW-1:0] rdata_a;
	logic [DW-1:0] rdata_b;

	logic accept;
	logic [TIME_W:0] sum;
	ftime_t sat_time;
	logic [XW-1:0] lidx;
	logic [XW-1:0] ridx;
	logic lv;
	logic rv;
	ftime_t l_time;
	ftime_t r_time;
	logic [IDW-1:0] l_id;
	logic [IDW-1:0] r_id;
	logic l_before_m;
	logic r_before_m;
	logic r_before_l;
	logic take_l;
	logic take_r;
	logic out_free;
	logic [IDW+OUT_ID_W-1:0] asg_ext;
	logic [IDW+OUT_ID_W-1:0] top_ext;

	efsa_heap_mem #(
		.DEPTH (MAX_SERVERS),
		.DW    (DW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (rd_left[AW-1:0]),
		.raddr_b (rd_right[AW-1:0]),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// saturating add of service time to the top free time
	assign sum = {1'b0, top_time_q} + (TIME_W + 1)'(service_time);
	assign sat_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

	// children of the current position and their presence in the heap
	assign lidx = {1'b0, pos_q, 1'b1};
	assign ridx = lidx + XW'(1);
	assign lv = lidx < XW'(count_q);
	assign rv = ridx < XW'(count_q);
	assign {l_time, l_id} = rdata_a;
	assign {r_time, r_id} = rdata_b;

	// ordering: earlier time first, then lower server number
	assign l_before_m = (l_time < mov_time_q) || ((l_time == mov_time_q) && (l_id < mov_id_q));
	assign r_before_m = (r_time < mov_time_q) || ((r_time == mov_time_q) && (r_id < mov_id_q));
	assign r_before_l = (r_time < l_time) || ((r_time == l_time) && (r_id < l_id));
	assign take_l = lv && l_before_m && !(rv && r_before_l);
	assign take_r = rv && r_before_m && !(lv && l_before_m && !r_before_l);

	// next read position: root on a new customer, chosen child while sifting
	always_comb begin
		rd_pos = '0;
		if (state_q == S_SIFT) begin
			if (take_r) begin
				rd_pos = ridx[AW-1:0];
			end else if (take_l) begin
				rd_pos = lidx[AW-1:0];
			end
		end
	end
	assign rd_left = {1'b0, rd_pos, 1'b1};
	assign rd_right = rd_left + XW'(1);

	// memory write: clearing sweep or one sift step
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = {mov_time_q, mov_id_q};
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = {ftime_t'(0), IDW'(clr_addr_q) + IDW'(1)};
			end
			S_SIFT: begin
				mem_we = 1'b1;
				if (take_r) begin
					mem_wdata = rdata_b;
				end else if (take_l) begin
					mem_wdata = rdata_a;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_addr_q <= '0;
			restart_q <= 1'b0;
			count_q <= CW'(RST_COUNT);
			pos_q <= '0;
			top_time_q <= '0;
			top_id_q <= IDW'(1);
			assigned_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_ADDR) begin
						clr_addr_q <= '0;
						top_time_q <= '0;
						top_id_q <= IDW'(1);
						assigned_q <= '0;
						state_q <= restart_q ? S_DONE : S_IDLE;
						restart_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_RESTART) begin
							count_q <= count_new;
							clr_addr_q <= '0;
							restart_q <= 1'b1;
							state_q <= S_CLEAR;
						end else begin
							assigned_q <= top_id_q;
							pos_q <= '0;
							state_q <= S_SIFT;
						end
					end
				end
				S_SIFT: begin
					if (pos_q == '0) begin
						{top_time_q, top_id_q} <= mem_wdata;
					end
					if (take_l || take_r) begin
						pos_q <= rd_pos;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// moving entry, loaded from the top on a customer word
	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_CUSTOMER)) begin
			mov_time_q <= sat_time;
			mov_id_q <= top_id_q;
		end
	end

	// low seven bits of server numbers for the result
	assign asg_ext = {{OUT_ID_W{1'b0}}, assigned_q};
	assign top_ext = {{OUT_ID_W{1'b0}}, top_id_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_assigned_q <= asg_ext[OUT_ID_W-1:0];
			out_next_q <= top_ext[OUT_ID_W-1:0];
			out_time_q <= top_time_q;
		end
	end

	assign out_valid = out_valid_q;
	assign assigned_server = out_assigned_q;
	assign next_server = out_next_q;
	assign next_free_time = out_time_q;

endmodule

// ===== rtl/earliest_free_server_assigner_unit.sv =====
// earliest-free server assigner: min-heap of server free times in one memory
// customer word: the root is sifted down one sift level per cycle through the memory, then
//   the result is registered as the sequencer returns to idle for the next word
// restart word: the one-entry-per-cycle clearing sweep rewrites every heap entry, then the
//   result is registered; a stalled result holds the sequencer
// after reset the heap memory is cleared with in_ready low
module earliest_free_server_assigner_unit #(
	parameter int MAX_SERVERS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [efsa_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [efsa_pkg::SVC_W-1:0]    service_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [efsa_pkg::OUT_ID_W-1:0] assigned_server,
	output logic [efsa_pkg::OUT_ID_W-1:0] next_server,
	output logic [efsa_pkg::TIME_W-1:0]   next_free_time
);

	import efsa_pkg::*;

	localparam int CW = $clog2(MAX_SERVERS + 1);

	logic [CFG_W-1:0] siu_q;
	logic [CW-1:0] count_new;

	assign cfg_ready = 1'b1;

	// server count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			siu_q <= SIU_RESET;
		end else if (cfg_valid && cfg_ready) begin
			siu_q <= cfg_data;
		end
	end

	// clamp the count to 1..MAX_SERVERS
	always_comb begin
		priority if (siu_q == '0) begin
			count_new = CW'(1);
		end else if (32'(siu_q) > 32'(MAX_SERVERS)) begin
			count_new = CW'(MAX_SERVERS);
		end else begin
			count_new = CW'(siu_q);
		end
	end

	efsa_ctrl #(
		.MAX_SERVERS (MAX_SERVERS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.service_time    (service_time),
		.count_new       (count_new),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.assigned_server (assigned_server),
		.next_server     (next_server),
		.next_free_time  (next_free_time)
	);

endmodule

// ===== dv/earliest_free_server_assigner_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the earliest-free server assigner with its own heap predictor
module earliest_free_server_assigner_unit_tb;
	import efsa_pkg::*;

	localparam int SRV_MAX     = 64;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SEGMENTS    = 20;
	localparam int SEG_WORDS   = 55;
	localparam logic [TIME_W-1:0] TIME_SAT = '1;

	// one result word
	typedef struct packed {
		logic [OUT_ID_W-1:0] assigned;
		logic [OUT_ID_W-1:0] nserver;
		logic [TIME_W-1:0]   ntime;
	} pick_t;

	typedef enum logic {ROW_WORD, ROW_COUNT} row_kind_e;

	// directed stimulus row: an input word or a server count write
	typedef struct packed {
		row_kind_e        kind;
		logic             c;
		logic [SVC_W-1:0] svc;
		logic [CFG_W-1:0] count;
		logic             known;
		pick_t            pick;
	} dir_row_t;

	localparam pick_t NO_PICK = '0;
	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// fresh heap after reset, 64 servers at time 0
		'{ROW_WORD,  CMD_CUSTOMER, 16'h0000, 7'd0,   1'b1, '{7'd1, 7'd1, 32'd0}},
		'{ROW_WORD,  CMD_CUSTOMER, 16'hffff, 7'd0,   1'b1, '{7'd1, 7'd2, 32'd0}},
		// restart ignores the service time
		'{ROW_WORD,  CMD_RESTART,  16'hffff, 7'd0,   1'b1, '{7'd0, 7'd1, 32'd0}},
		// new count has no effect until the next restart
		'{ROW_COUNT, CMD_CUSTOMER, 16'h0000, 7'd1,   1'b0, NO_PICK},
		'{ROW_WORD,  CMD_CUSTOMER, 16'hffff, 7'd0,   1'b1, '{7'd1, 7'd2, 32'd0}},
		'{ROW_WORD,  CMD_RESTART,  16'h0000, 7'd0,   1'b1, '{7'd0, 7'd1, 32'd0}},
		'{ROW_WORD,  CMD_CUSTOMER, 16'd100,  7'd0,   1'b1, '{7'd1, 7'd1, 32'd100}},
		'{ROW_WORD,  CMD_CUSTOMER, 16'hffff, 7'd0,   1'b1, '{7'd1, 7'd1, 32'd65635}},
		// zero count is taken as one server
		'{ROW_COUNT, CMD_CUSTOMER, 16'h0000, 7'd0,   1'b0, NO_PICK},
		'{ROW_WORD,  CMD_RESTART,  16'h0000, 7'd0,   1'b1, '{7'd0, 7'd1, 32'd0}},
		'{ROW_WORD,  CMD_CUSTOMER, 16'd5,    7'd0,   1'b1, '{7'd1, 7'd1, 32'd5}},
		// count above the maximum is clamped
		'{ROW_COUNT, CMD_CUSTOMER, 16'h0000, 7'd127, 1'b0, NO_PICK},
		'{ROW_WORD,  CMD_RESTART,  16'h0000, 7'd0,   1'b1, '{7'd0, 7'd1, 32'd0}},
		'{ROW_WORD,  CMD_CUSTOMER, 16'd7,    7'd0,   1'b1, '{7'd1, 7'd2, 32'd0}},
		// two servers, ties go to the lower number
		'{ROW_COUNT, CMD_CUSTOMER, 16'h0000, 7'd2,   1'b0, NO_PICK},
		'{ROW_WORD,  CMD_RESTART,  16'h0000, 7'd0,   1'b1, '{7'd0, 7'd1, 32'd0}},
		'{ROW_WORD,  CMD_CUSTOMER, 16'd10,   7'd0,   1'b1, '{7'd1, 7'd2, 32'd0}},
		'{ROW_WORD,  CMD_CUSTOMER, 16'd10,   7'd0,   1'b1, '{7'd2, 7'd1, 32'd10}},
		'{ROW_WORD,  CMD_CUSTOMER, 16'd3,    7'd0,   1'b1, '{7'd1, 7'd2, 32'd10}},
		'{ROW_WORD,  CMD_CUSTOMER, 16'd3,    7'd0,   1'b1, '{7'd2, 7'd1, 32'd13}},
		// back to the full heap, checked by the predictor
		'{ROW_COUNT, CMD_CUSTOMER, 16'h0000, 7'd64,  1'b0, NO_PICK},
		'{ROW_WORD,  CMD_RESTART,  16'h0000, 7'd0,   1'b1, '{7'd0, 7'd1, 32'd0}},
		'{ROW_WORD,  CMD_CUSTOMER, 16'h5555, 7'd0,   1'b0, NO_PICK},
		'{ROW_WORD,  CMD_CUSTOMER, 16'haaaa, 7'd0,   1'b0, NO_PICK},
		'{ROW_WORD,  CMD_CUSTOMER, 16'h1234, 7'd0,   1'b0, NO_PICK}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 cmd = CMD_CUSTOMER;
	logic [SVC_W-1:0]     service_time = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [OUT_ID_W-1:0]  assigned_server;
	logic [OUT_ID_W-1:0]  next_server;
	logic [TIME_W-1:0]    next_free_time;

	// predictor state
	logic [TIME_W-1:0]    srv_time [SRV_MAX];
	logic [OUT_ID_W-1:0]  srv_id [SRV_MAX];
	int                   heap_size;
	logic [CFG_W-1:0]     count_shadow;

	pick_t                pick_queue [$];
	int                   mismatches = 0;
	int                   cycle_count = 0;
	int                   in_gap_pct = 0;
	int                   out_stall_pct = 0;

	earliest_free_server_assigner_unit #(
		.MAX_SERVERS(SRV_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.service_time(service_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.assigned_server(assigned_server),
		.next_server(next_server),
		.next_free_time(next_free_time)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// heap order: earlier free time first, then lower server number
	function automatic bit ahead_of(int a, int b);
		if (srv_time[a] != srv_time[b])
			return srv_time[a] < srv_time[b];
		return srv_id[a] < srv_id[b];
	endfunction

	// all servers free at time 0, latch the clamped count
	function automatic void reload_heap();
		int n;
		n = int'(count_shadow);
		if (n < 1)
			n = 1;
		if (n > SRV_MAX)
			n = SRV_MAX;
		heap_size = n;
		for (int i = 0; i < SRV_MAX; i++) begin
			srv_time[i] = '0;
			srv_id[i] = OUT_ID_W'(i + 1);
		end
	endfunction

	// push the root down to its place
	function automatic void sink_root();
		int pos;
		int lch;
		int best;
		bit done;
		logic [TIME_W-1:0] t;
		logic [OUT_ID_W-1:0] d;
		pos = 0;
		done = 1'b0;
		while (!done) begin
			lch = 2 * pos + 1;
			best = pos;
			if (lch < heap_size && ahead_of(lch, best))
				best = lch;
			if (lch + 1 < heap_size && ahead_of(lch + 1, best))
				best = lch + 1;
			if (best == pos) begin
				done = 1'b1;
			end else begin
				t = srv_time[pos];
				d = srv_id[pos];
				srv_time[pos] = srv_time[best];
				srv_id[pos] = srv_id[best];
				srv_time[best] = t;
				srv_id[best] = d;
				pos = best;
			end
		end
	endfunction

	// apply one word to the heap and return the result it yields
	function automatic pick_t advance_heap(logic c, logic [SVC_W-1:0] svc);
		pick_t p;
		logic [TIME_W:0] sum;
		p.assigned = '0;
		if (c == CMD_RESTART) begin
			reload_heap();
		end else begin
			sum = {1'b0, srv_time[0]} + {{(TIME_W + 1 - SVC_W){1'b0}}, svc};
			p.assigned = srv_id[0];
			srv_time[0] = sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];
			sink_root();
		end
		p.nserver = srv_id[0];
		p.ntime = srv_time[0];
		return p;
	endfunction

	// offer one word, predict on acceptance, then maybe idle
	task automatic send_word(input logic c, input logic [SVC_W-1:0] svc, input logic known,
			input pick_t typed);
		pick_t p;
		in_valid <= 1'b1;
		cmd <= c;
		service_time <= svc;
		do @(posedge clk); while (!in_ready);
		p = advance_heap(c, svc);
		pick_queue.push_back(known ? typed : p);
		if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			cmd <= 1'($urandom_range(1));
			service_time <= SVC_W'($urandom_range(65535));
			do @(posedge clk); while ($urandom_range(99) < in_gap_pct);
		end
	endtask

	// hold off the sender until every pending result is back
	task automatic settle_queue();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pick_queue.size() != 0)
			@(posedge clk);
	endtask

	// server count write, only with the block idle
	task automatic write_count(input logic [CFG_W-1:0] v);
		settle_queue();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		count_shadow = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic flag_mismatch(input string field, input longint unsigned want,
			input longint unsigned got);
		mismatches++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// result side: random stalls and comparison against the oldest expectation
	always @(posedge clk) begin : result_monitor
		pick_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pick_queue.size() == 0) begin
					flag_mismatch("unexpected word, assigned_server", 0, assigned_server);
				end else begin
					want = pick_queue.pop_front();
					if (assigned_server !== want.assigned)
						flag_mismatch("assigned_server", want.assigned, assigned_server);
					if (next_server !== want.nserver)
						flag_mismatch("next_server", want.nserver, next_server);
					if (next_free_time !== want.ntime)
						flag_mismatch("next_free_time", want.ntime, next_free_time);
				end
			end
			out_ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	// run limit
	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : main
		int r;
		logic [CFG_W-1:0] cnt;
		logic [SVC_W-1:0] svc;

		count_shadow = SIU_RESET;
		reload_heap();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int k = 0; k < DIR_ROWS; k++) begin
			if (DIRECTED[k].kind == ROW_COUNT)
				write_count(DIRECTED[k].count);
			else
				send_word(DIRECTED[k].c, DIRECTED[k].svc, DIRECTED[k].known, DIRECTED[k].pick);
		end

		// random segments, each with its own server count write; the idling mode changes every five segments
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: cnt = SIU_RESET;
				1: cnt = 7'd1;
				2: cnt = '1;
				3: cnt = '0;
				default: begin
					case ($urandom_range(7))
						0: cnt = 7'd1;
						1: cnt = 7'd2;
						2: cnt = 7'd3;
						3: cnt = 7'd64;
						4: cnt = 7'd127;
						default: cnt = CFG_W'($urandom_range(127));
					endcase
				end
			endcase
			write_count(cnt);
			case (seg / 5)
				0: begin
					in_gap_pct = 0;
					out_stall_pct = 0;
				end
				1: begin
					in_gap_pct = 53;
					out_stall_pct = 0;
				end
				2: begin
					in_gap_pct = 0;
					out_stall_pct = 53;
				end
				default: begin
					in_gap_pct = 30;
					out_stall_pct = 30;
				end
			endcase
			// mostly start from a clean heap, sometimes keep the old one
			if ($urandom_range(99) < 85)
				send_word(CMD_RESTART, SVC_W'($urandom_range(65535)), 1'b0, NO_PICK);
			for (int k = 0; k < SEG_WORDS; k++) begin
				if ($urandom_range(99) < 2)
					settle_queue();
				r = $urandom_range(99);
				if (r < 3) begin
					send_word(CMD_RESTART, SVC_W'($urandom_range(65535)), 1'b0, NO_PICK);
				end else begin
					if (r < 35)
						svc = SVC_W'($urandom_range(15));
					else if (r < 40)
						svc = '0;
					else if (r < 45)
						svc = '1;
					else
						svc = SVC_W'($urandom_range(65535));
					send_word(CMD_CUSTOMER, svc, 1'b0, NO_PICK);
				end
			end
		end

		// wait out the last results and any stray words
		settle_queue();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pick_queue.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== earliest_free_server_assigner_unit.f =====
rtl/efsa_pkg.sv
rtl/efsa_heap_mem.sv
rtl/efsa_ctrl.sv
rtl/earliest_free_server_assigner_unit.sv
dv/earliest_free_server_assigner_unit_tb.sv
